@@ design/assert_macros.svh @@
// Shared assertion macros for the depth smoother checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/rmds_pkg.sv @@
`default_nettype none

package rmds_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int OUT_W        = 24;
    localparam int WEIGHT_W     = 9;
    // Ages run up to 31 for the longest supported window
    localparam int AGE_W        = 5;
    localparam int WEIGHT_ONE   = 256;
    localparam int WEIGHT_RESET = 179;

    // One sorted entry: sample and its age, 0 = newest
    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic [AGE_W-1:0]    age;
    } rmds_entry_t;

    // Data and control handed from one cell to the next one up the chain
    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic [AGE_W-1:0]    age;
        logic                valid;
        logic                goes_up;
        logic                evict_seen;
    } rmds_link_t;

endpackage

`default_nettype wire

@@ design/running_median_depth_smoother.sv @@
// The accepted sample is registered in the hold stage and then in the smoother and
// output stage; a stall on the output can hold it in the hold stage in between.
// Throughput: one sample per cycle while the output is not stalled; the sorted
// cell chain inserts and evicts one entry per cycle and the smoother updates once.
// Reset clears the cell and stage valid bits, the smoothed value (to zero) and the
// weight (to 179); held samples need no clearing pass.
`default_nettype none

module running_median_depth_smoother #(
    parameter int WINDOW_LEN = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rmds_pkg::SAMPLE_W-1:0] depth_sample,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rmds_pkg::OUT_W-1:0]    smoothed_depth,
    output logic                               window_full,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rmds_pkg::WEIGHT_W-1:0] cfg_wr_data
);
    import rmds_pkg::*;

    localparam int NCELL   = WINDOW_LEN - 1;
    localparam int MED_IDX = WINDOW_LEN / 2;

    rmds_link_t          up_link [NCELL+1];
    rmds_entry_t         post    [NCELL+1];
    logic                in_fire;
    logic                out_fire;
    logic                smooth_fire;
    logic                full;
    logic [SAMPLE_W-1:0] chosen;

    logic [WEIGHT_W-1:0] weight_reg;
    logic                s1_vld_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_full_reg;
    logic                out_vld_reg;
    logic                out_full_reg;

    // Handshake
    assign smooth_fire = s1_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall    = s1_vld_reg && !smooth_fire;
    assign in_fire     = in_valid && !in_stall;
    assign out_fire    = out_vld_reg && !out_stall;

    // Bottom of the chain: always valid, nothing moves up from below
    assign up_link[0] = '{val: '0, age: '0, valid: 1'b1, goes_up: 1'b0, evict_seen: 1'b0};
    assign full       = up_link[NCELL].valid;

    // Past the top cell: the position that exists only after an insert
    always_comb
    begin
        if (up_link[NCELL].goes_up)
        begin
            post[NCELL].val = up_link[NCELL].val;
            post[NCELL].age = up_link[NCELL].age + AGE_W'(1);
        end
        else
        begin
            post[NCELL].val = depth_sample;
            post[NCELL].age = '0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_cell
            rmds_cell #(
                .WINDOW_LEN(WINDOW_LEN)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .step      (in_fire),
                .sample    (depth_sample),
                .full      (full),
                .below     (up_link[gi]),
                .above_post(post[gi+1]),
                .up_out    (up_link[gi+1]),
                .post_out  (post[gi])
            );
        end
    endgenerate

    // Median of the full window, else the raw sample
    assign chosen = full ? post[MED_IDX].val : depth_sample;

    // Weight register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_W'(WEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            weight_reg <= cfg_wr_data;
        end
    end

    // Hold the chosen sample until the smoother takes it
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_sample_reg <= chosen;
            s1_full_reg   <= full;
        end
        if (smooth_fire)
        begin
            out_full_reg <= s1_full_reg;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (smooth_fire)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (smooth_fire)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    rmds_smoother u_smoother (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (smooth_fire),
        .sample(s1_sample_reg),
        .weight(weight_reg),
        .value (smoothed_depth)
    );

    assign out_valid   = out_vld_reg;
    assign window_full = out_full_reg;

endmodule

`default_nettype wire

@@ design/rmds_cell.sv @@
`default_nettype none

module rmds_cell #(
    parameter int WINDOW_LEN = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [rmds_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                          full,
    input  wire rmds_pkg::rmds_link_t          below,
    input  wire rmds_pkg::rmds_entry_t         above_post,
    output rmds_pkg::rmds_link_t               up_out,
    output rmds_pkg::rmds_entry_t              post_out
);
    import rmds_pkg::*;

    logic [SAMPLE_W-1:0] val_reg;
    logic [AGE_W-1:0]    age_reg;
    logic                valid_reg;
    logic                goes_up;
    logic                evict_here;
    logic                evict_seen;
    rmds_entry_t         post;
    rmds_entry_t         entry_next;

    // Insert the new sample, then close the gap left by the oldest entry
    always_comb
    begin
        goes_up = !valid_reg || (sample < val_reg);
        if (below.goes_up)
        begin
            post.val = below.val;
            post.age = below.age + AGE_W'(1);
        end
        else if (goes_up)
        begin
            post.val = sample;
            post.age = '0;
        end
        else
        begin
            post.val = val_reg;
            post.age = age_reg + AGE_W'(1);
        end
        evict_here = full && (post.age == AGE_W'(WINDOW_LEN - 1));
        evict_seen = below.evict_seen || evict_here;
        entry_next = evict_seen ? above_post : post;
    end

    assign up_out.val        = val_reg;
    assign up_out.age        = age_reg;
    assign up_out.valid      = valid_reg;
    assign up_out.goes_up    = goes_up;
    assign up_out.evict_seen = evict_seen;
    assign post_out          = post;

    // Hold the entry, advance on each accepted sample
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            val_reg <= entry_next.val;
            age_reg <= entry_next.age;
        end
    end

    // Fill upward one cell per sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step)
        begin
            valid_reg <= below.valid;
        end
    end

endmodule

`default_nettype wire

@@ design/rmds_smoother.sv @@
`default_nettype none

module rmds_smoother (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [rmds_pkg::SAMPLE_W-1:0] sample,
    input  wire logic [rmds_pkg::WEIGHT_W-1:0] weight,
    output logic      [rmds_pkg::OUT_W-1:0]    value
);
    import rmds_pkg::*;

    localparam int PROD_W = OUT_W + WEIGHT_W;
    localparam int SUM_W  = PROD_W + 2;

    logic [OUT_W-1:0]      value_reg;
    logic [OUT_W-1:0]      value_next;
    logic [WEIGHT_W-1:0]   w_sat;
    logic [WEIGHT_W-1:0]   w_old;
    logic [PROD_W-1:0]     prod_old;
    logic [PROD_W-1:0]     prod_new;
    logic [SUM_W-1:0]      sum;

    // Blend old and new in Q8, round half up
    always_comb
    begin
        w_sat    = (weight > WEIGHT_W'(WEIGHT_ONE)) ? WEIGHT_W'(WEIGHT_ONE) : weight;
        w_old    = WEIGHT_W'(WEIGHT_ONE) - w_sat;
        prod_old = PROD_W'(value_reg) * PROD_W'(w_old);
        prod_new = PROD_W'({sample, 8'h00}) * PROD_W'(w_sat);
        sum      = SUM_W'(prod_old) + SUM_W'(prod_new) + SUM_W'(128);
        value_next = sum[OUT_W+7:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (load)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

@@ design/rmds_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module rmds_checker #(
    parameter int WINDOW_LEN = 11
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [rmds_pkg::OUT_W-1:0]    smoothed_depth,
    input wire logic                          window_full
);
    import rmds_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    logic [CNT_W-1:0] done_reg;
    logic [1:0]       pend_reg;
    logic             in_fire;
    logic             out_fire;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // Count delivered results (saturating) and items in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (out_fire && (done_reg != CNT_W'(WINDOW_LEN)))
            begin
                done_reg <= done_reg + CNT_W'(1);
            end
            pend_reg <= pend_reg + 2'(in_fire) - 2'(out_fire);
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_data_hold, clk, rst_n, out_valid && out_stall, $stable(smoothed_depth))
    `ASSERT_IMPLIES(a_full_flag, clk, rst_n, out_valid, window_full == (done_reg >= CNT_W'(WINDOW_LEN - 1)))
    `ASSERT_IMPLIES(a_no_extra, clk, rst_n, out_valid, pend_reg != 2'd0)

endmodule

bind running_median_depth_smoother rmds_checker #(
    .WINDOW_LEN(WINDOW_LEN)
) u_rmds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .smoothed_depth(smoothed_depth),
    .window_full   (window_full)
);

`default_nettype wire

@@ test/running_median_depth_smoother_tb.sv @@
`default_nettype none

module running_median_depth_smoother_tb;

    import rmds_pkg::*;

    localparam int WINDOW_LEN  = 11;
    localparam int IDLE_PCT    = 22;
    localparam int HOLD_CYCLES = 60;
    localparam int HOLD_AFTER  = 150;
    localparam int DRAIN_PAUSE = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 90;

    localparam logic [SAMPLE_W-1:0] DEPTH_MAX  = '1;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;

    typedef struct {
        logic [OUT_W-1:0] depth;
        logic             full;
    } depth_result_t;

    // Tracks the window and the smoother, and holds expected results in order
    class depth_smoother_tracker;
        logic [SAMPLE_W-1:0] recent_q[$];
        depth_result_t       pending_q[$];
        logic [WEIGHT_W-1:0] weight;
        logic [OUT_W-1:0]    smoothed;
        int                  errors;
        int                  samples_seen;
        int                  results_seen;
        int                  full_seen;

        function new();
            weight   = WEIGHT_W'(WEIGHT_RESET);
            smoothed = '0;
        endfunction

        // Median of the held window: the entry of rank WINDOW_LEN/2, ties by position
        function logic [SAMPLE_W-1:0] window_median();
            int rank;
            for (int i = 0; i < recent_q.size(); i++)
            begin
                rank = 0;
                for (int j = 0; j < recent_q.size(); j++)
                    if (recent_q[j] < recent_q[i] || (recent_q[j] == recent_q[i] && j < i))
                        rank++;
                if (rank == WINDOW_LEN / 2)
                    return recent_q[i];
            end
            return '0;
        endfunction

        // Note an accepted sample and queue the result it causes
        function void take_sample(logic [SAMPLE_W-1:0] s);
            depth_result_t   r;
            logic [SAMPLE_W-1:0] chosen;
            longint unsigned w;
            longint unsigned total;
            samples_seen++;
            recent_q.insert(recent_q.size(), s);
            r.full = (recent_q.size() == WINDOW_LEN);
            if (r.full)
            begin
                chosen = window_median();
                recent_q.delete(0);
            end
            else
                chosen = s;
            w        = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
            total    = longint'(smoothed) * (WEIGHT_ONE - w) + (longint'(chosen) << 8) * w;
            smoothed = OUT_W'((total + 128) >> 8);
            r.depth  = smoothed;
            pending_q.insert(pending_q.size(), r);
        endfunction

        // Compare one delivered result with the oldest expectation
        function void compare_output(logic [OUT_W-1:0] depth, logic full);
            depth_result_t r;
            results_seen++;
            if (full)
                full_seen++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result depth=%h full=%b", $time, depth, full);
                errors++;
                return;
            end
            r = pending_q[0];
            pending_q.delete(0);
            if (depth !== r.depth)
            begin
                $display("%0t: smoothed_depth expected %h actual %h", $time, r.depth, depth);
                errors++;
            end
            if (full !== r.full)
            begin
                $display("%0t: window_full expected %b actual %b", $time, r.full, full);
                errors++;
            end
        endfunction
    endclass

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [SAMPLE_W-1:0] depth_sample = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [OUT_W-1:0]    smoothed_depth;
    logic                window_full;
    logic                cfg_wr_en    = 1'b0;
    logic [WEIGHT_W-1:0] cfg_wr_data  = '0;

    depth_smoother_tracker tracker = new();
    bit                    no_idle = 1'b0;
    bit                    hold_done = 1'b0;
    int                    quiet_cycles = 0;
    int                    weights_used = 0;

    running_median_depth_smoother #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .depth_sample   (depth_sample),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .smoothed_depth (smoothed_depth),
        .window_full    (window_full),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_output(smoothed_depth, window_full);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         tracker.pending_q.size());
                $display("TEST FAILED");
                $finish;
            end
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && tracker.results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Offer one sample, with an optional random gap, and hold it until taken
    task automatic send_depth(input logic [SAMPLE_W-1:0] s);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        depth_sample <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_sample(s);
    endtask

    // Wait until every expected result is out, then let the pipeline settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (tracker.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Write the smoother weight while the block is idle
    task automatic set_weight(input logic [WEIGHT_W-1:0] w);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.weight = w;
        weights_used++;
    endtask

    // Random phase: mostly a noisy steady depth, plus outliers, extremes and repeats
    task automatic run_phase(input logic [WEIGHT_W-1:0] w, input bit calm);
        int                  base;
        int                  v;
        int                  pick;
        logic [SAMPLE_W-1:0] last_s;
        set_weight(w);
        no_idle = calm;
        base    = $urandom_range(65535);
        last_s  = '0;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                if ($urandom_range(19) == 0)
                    base = $urandom_range(65535);
                v = base + $urandom_range(128) - 64;
                v = (v < 0) ? 0 : ((v > 65535) ? 65535 : v);
            end
            else if (pick < 82)
                v = $urandom_range(65535);
            else if (pick < 90)
                v = $urandom_range(1) ? 65535 : 0;
            else
                v = last_s;
            last_s = SAMPLE_W'(v);
            send_depth(last_s);
        end
        drain_results();
        no_idle = 1'b0;
    endtask

    initial
    begin
        logic [SAMPLE_W-1:0] directed_q[$];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes and bit patterns while filling, ties once the window is full
        directed_q = '{16'h0000, DEPTH_MAX, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFFE,
                       16'h03E8, 16'h03E8, 16'h03E8, 16'h07D0, 16'h0000,
                       16'h03E8, 16'h03E8, DEPTH_MAX, DEPTH_MAX, 16'h0000,
                       16'h1234, 16'h1234, 16'h1234, 16'hFFFF, 16'h8000, 16'h7FFF};
        foreach (directed_q[i])
            send_depth(directed_q[i]);
        set_weight(WEIGHT_MAX);
        send_depth(16'h4321);
        send_depth(16'h0000);
        drain_results();

        // Random phases across the weight range, saturation and both ends included
        run_phase(WEIGHT_W'(WEIGHT_RESET), 1'b0);
        run_phase(WEIGHT_W'($urandom_range(1, 255)), 1'b0);
        run_phase('0, 1'b0);
        run_phase(WEIGHT_W'(WEIGHT_ONE), 1'b1);
        run_phase(WEIGHT_W'($urandom_range(257, 510)), 1'b0);
        run_phase(WEIGHT_MAX, 1'b0);

        drain_results();
        $display("Ran %0d depth samples through %0d weight settings; %0d results checked,",
                 tracker.samples_seen, weights_used, tracker.results_seen);
        $display("%0d of them from a full median window, with %0d mismatches.",
                 tracker.full_seen, tracker.errors);
        if (tracker.errors == 0 && tracker.pending_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
